// ===== hw/rtl/drt_pkg.sv =====
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, constants and helpers for the delimited row tokenizer.
// ----------------------------------------------------------------------------
package drt_pkg;

   localparam int MAX_DELIM_LEN = 4;
   // widest delimiter that fits the 32-bit packed register
   localparam int PACKED_LIMIT  = 4;
   localparam int DELIM_LIM     = (MAX_DELIM_LEN < PACKED_LIMIT) ? MAX_DELIM_LEN : PACKED_LIMIT;
   localparam int DLEN_W        = $clog2(MAX_DELIM_LEN + 1);
   localparam int HIDX_W        = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

   localparam logic [7:0] QUOTE_CHAR = 8'h22;

   // queue between front and back, power of two
   localparam int Q_DEPTH = 4;
   localparam int Q_IDX_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // result token codes
   localparam logic [1:0] TOK_CONTENT   = 2'd0;
   localparam logic [1:0] TOK_FIELD_END = 2'd1;
   localparam logic [1:0] TOK_ROW_END   = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_BYTES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ITEM_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTES_EN  = 3'd4;

   typedef enum logic [1:0] {
      ENT_LINE,
      ENT_ROW,
      ENT_EOS
   } ent_kind_type;

   // one classified input item: line bytes, a row end or an end of stream
   typedef struct packed {
      ent_kind_type                     kind;
      logic [DLEN_W-1:0]                cnt;
      logic [MAX_DELIM_LEN-1:0][7:0]    bytes;
   } entry_type;

   typedef struct packed {
      logic [31:0] row_bytes;
      logic [2:0]  row_count;
      logic [31:0] item_bytes;
      logic [2:0]  item_count;
      logic        quotes_en;
   } cfg_type;

   function automatic logic [DLEN_W-1:0] eff_len(input logic [2:0] count);
      logic [DLEN_W-1:0] r;
      if (count == 3'd0) begin
         r = DLEN_W'(1);
      end else if (int'(count) > DELIM_LIM) begin
         r = DLEN_W'(DELIM_LIM);
      end else begin
         r = DLEN_W'(count);
      end
      return r;
   endfunction

   function automatic logic [7:0] delim_byte(input logic [31:0] pbytes,
                                             input logic [DLEN_W-1:0] k);
      logic [1:0] sel;
      sel = 2'(k);
      return pbytes[8*sel +: 8];
   endfunction

endpackage

// ===== hw/rtl/drt_front.sv =====
// ----------------------------------------------------------------------------
// drt_front
// Accepts stream bytes, runs the row delimiter matcher and queues line work.
// ----------------------------------------------------------------------------
module drt_front (
   input  logic                clock,
   input  logic                reset,
   input  drt_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_text_byte,
   input  logic                req_stream_end,
   input  logic                fifo_full,
   output logic                push,
   output drt_pkg::entry_type  push_entry
);

   logic [7:0]                   row_hold_ff [drt_pkg::MAX_DELIM_LEN];
   logic [drt_pkg::DLEN_W-1:0]   row_len_ff, row_len_in;
   logic [drt_pkg::DLEN_W-1:0]   rlen, len_inc;
   logic                         accept, rmatch, hold_we;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;
   assign rlen      = drt_pkg::eff_len(cfg.row_count);
   assign len_inc   = row_len_ff + drt_pkg::DLEN_W'(1);
   assign rmatch    = (row_len_ff < rlen) &&
                      (req_text_byte == drt_pkg::delim_byte(cfg.row_bytes, row_len_ff));

   always_comb begin
      push            = 1'b0;
      hold_we         = 1'b0;
      row_len_in      = row_len_ff;
      push_entry.kind = drt_pkg::ENT_LINE;
      push_entry.cnt  = len_inc;
      // held bytes first, the breaking byte right after them
      for (int j = 0; j < drt_pkg::MAX_DELIM_LEN; j++) begin
         push_entry.bytes[j] = (int'(row_len_ff) == j) ? req_text_byte : row_hold_ff[j];
      end
      if (accept) begin
         if (req_stream_end) begin
            push            = 1'b1;
            push_entry.kind = drt_pkg::ENT_EOS;
            row_len_in      = '0;
         end else if (rmatch) begin
            if (len_inc >= rlen) begin
               push            = 1'b1;
               push_entry.kind = drt_pkg::ENT_ROW;
               row_len_in      = '0;
            end else begin
               hold_we    = 1'b1;
               row_len_in = len_inc;
            end
         end else begin
            push       = 1'b1;
            row_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff <= '0;
      end else begin
         row_len_ff <= row_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_we) begin
         row_hold_ff[row_len_ff[drt_pkg::HIDX_W-1:0]] <= req_text_byte;
      end
   end

endmodule

// ===== hw/rtl/drt_fifo.sv =====
// ----------------------------------------------------------------------------
// drt_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module drt_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  drt_pkg::entry_type  push_entry,
   input  logic                pop,
   output drt_pkg::entry_type  head,
   output logic                not_empty,
   output logic                full
);

   drt_pkg::entry_type              mem_ff [drt_pkg::Q_DEPTH];
   logic [drt_pkg::Q_IDX_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [drt_pkg::Q_IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [drt_pkg::Q_CNT_W-1:0]     count_ff, count_in;

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == drt_pkg::Q_CNT_W'(drt_pkg::Q_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + drt_pkg::Q_IDX_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + drt_pkg::Q_IDX_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + drt_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - drt_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/drt_back.sv =====
// ----------------------------------------------------------------------------
// drt_back
// Item delimiter matcher, quote handling and token sequencer with a two-deep
// result stage; tokens leave one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module drt_back (
   input  logic                clock,
   input  logic                reset,
   input  drt_pkg::cfg_type    cfg,
   input  drt_pkg::entry_type  head,
   input  logic                head_valid,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic [1:0]          rsp_token_kind,
   output logic                rsp_burst_last
);

   localparam int DW = drt_pkg::DLEN_W;
   localparam int HW = drt_pkg::HIDX_W;

   // matcher and field state
   logic [7:0]     item_hold_ff [drt_pkg::MAX_DELIM_LEN];
   logic [DW-1:0]  iml_ff, iml_in;
   logic [DW-1:0]  rp_ff, rp_in;
   logic [HW-1:0]  bi_ff, bi_in;
   logic           quote_ff, quote_in;
   logic           fclosed_ff, fclosed_in;
   logic           line_ff, line_in;
   logic           fpend_ff, fpend_in;

   // staging: h holds a token until it is known whether it ends the burst
   logic           h_valid_ff, h_valid_in;
   logic           h_res_ff, h_res_in;
   logic           h_last_ff, h_last_in;
   logic [7:0]     h_byte_ff, h_byte_in;
   logic [1:0]     h_kind_ff, h_kind_in;
   logic           o_valid_ff, o_valid_in;
   logic           o_last_ff, o_last_in;
   logic [7:0]     o_byte_ff, o_byte_in;
   logic [1:0]     o_kind_ff, o_kind_in;

   logic [7:0]     cur_byte, e_byte;
   logic [1:0]     e_kind;
   logic [DW-1:0]  ilen, iml_inc, rp_inc, nrel;
   logic           last_byte, is_quote, opening, closing, in_quote_plain;
   logic           fc_eff, imatch, release_hold, finish;
   logic           emit, step_end, hold_we, fire;
   logic           o_free, h_move, h_free;

   assign cur_byte  = head.bytes[bi_ff];
   assign last_byte = (DW'(bi_ff) + DW'(1)) == head.cnt;
   assign ilen      = drt_pkg::eff_len(cfg.item_count);
   assign iml_inc   = iml_ff + DW'(1);
   assign rp_inc    = rp_ff + DW'(1);

   assign is_quote       = cfg.quotes_en && (cur_byte == drt_pkg::QUOTE_CHAR);
   assign opening        = is_quote && !quote_ff;
   assign closing        = is_quote && quote_ff;
   assign in_quote_plain = quote_ff && !is_quote;
   assign fc_eff         = fclosed_ff || closing;
   assign imatch         = !opening && !in_quote_plain && (iml_ff < ilen) &&
                           (cur_byte == drt_pkg::delim_byte(cfg.item_bytes, iml_ff));
   assign release_hold   = opening || (!in_quote_plain && !imatch);

   always_comb begin
      emit       = 1'b0;
      e_byte     = 8'd0;
      e_kind     = drt_pkg::TOK_CONTENT;
      step_end   = 1'b0;
      finish     = 1'b0;
      hold_we    = 1'b0;
      nrel       = '0;
      iml_in     = iml_ff;
      rp_in      = rp_ff;
      bi_in      = bi_ff;
      quote_in   = quote_ff;
      fclosed_in = fclosed_ff;
      line_in    = line_ff;
      fpend_in   = fpend_ff;
      if (head_valid) begin
         unique case (head.kind)
            drt_pkg::ENT_LINE: begin
               nrel = (release_hold && !fc_eff) ? iml_ff : '0;
               if (rp_ff < nrel) begin
                  // give back one held item delimiter byte as content
                  emit   = 1'b1;
                  e_byte = item_hold_ff[rp_ff[HW-1:0]];
                  if (opening && (rp_inc == nrel)) begin
                     finish = 1'b1;
                  end else begin
                     rp_in = rp_inc;
                  end
               end else begin
                  finish = 1'b1;
                  if (opening) begin
                     emit = 1'b0;
                  end else if (in_quote_plain) begin
                     emit   = !fclosed_ff;
                     e_byte = cur_byte;
                  end else if (imatch) begin
                     emit   = (iml_inc >= ilen);
                     e_kind = drt_pkg::TOK_FIELD_END;
                  end else begin
                     emit   = !fc_eff;
                     e_byte = cur_byte;
                  end
               end
               if (finish) begin
                  line_in = 1'b1;
                  rp_in   = '0;
                  if (opening) begin
                     quote_in = 1'b1;
                     iml_in   = '0;
                     fpend_in = 1'b1;
                  end else if (in_quote_plain) begin
                     fpend_in = 1'b1;
                  end else begin
                     if (closing) begin
                        quote_in   = 1'b0;
                        fclosed_in = 1'b1;
                     end
                     if (imatch) begin
                        hold_we = 1'b1;
                        if (iml_inc >= ilen) begin
                           iml_in     = '0;
                           fclosed_in = 1'b0;
                           fpend_in   = 1'b0;
                        end else begin
                           iml_in   = iml_inc;
                           fpend_in = 1'b1;
                        end
                     end else begin
                        iml_in   = '0;
                        fpend_in = 1'b1;
                     end
                  end
                  if (last_byte) begin
                     step_end = 1'b1;
                     bi_in    = '0;
                  end else begin
                     bi_in = bi_ff + HW'(1);
                  end
               end
            end
            drt_pkg::ENT_ROW,
            drt_pkg::ENT_EOS: begin
               nrel = fclosed_ff ? '0 : iml_ff;
               if ((head.kind == drt_pkg::ENT_EOS) && !line_ff) begin
                  // end of stream on an empty line: just clear
                  step_end   = 1'b1;
                  iml_in     = '0;
                  rp_in      = '0;
                  quote_in   = 1'b0;
                  fclosed_in = 1'b0;
                  fpend_in   = 1'b0;
               end else if (rp_ff < nrel) begin
                  emit   = 1'b1;
                  e_byte = item_hold_ff[rp_ff[HW-1:0]];
                  rp_in  = rp_inc;
               end else if (fpend_ff) begin
                  emit     = 1'b1;
                  e_kind   = drt_pkg::TOK_FIELD_END;
                  fpend_in = 1'b0;
               end else begin
                  emit       = 1'b1;
                  e_kind     = drt_pkg::TOK_ROW_END;
                  step_end   = 1'b1;
                  iml_in     = '0;
                  rp_in      = '0;
                  quote_in   = 1'b0;
                  fclosed_in = 1'b0;
                  line_in    = 1'b0;
                  fpend_in   = 1'b0;
               end
            end
            default: begin
               step_end = 1'b1;
            end
         endcase
      end
   end

   // result staging
   assign o_free = !o_valid_ff || !rsp_stall;
   assign h_move = h_valid_ff && (h_res_ff || emit) && o_free;
   assign h_free = !h_valid_ff || h_move;
   assign fire   = head_valid && (!emit || h_free);
   assign pop    = fire && step_end;

   always_comb begin
      h_valid_in = h_valid_ff;
      h_res_in   = h_res_ff;
      h_last_in  = h_last_ff;
      h_byte_in  = h_byte_ff;
      h_kind_in  = h_kind_ff;
      if (fire && emit) begin
         h_valid_in = 1'b1;
         h_res_in   = step_end;
         h_last_in  = step_end;
         h_byte_in  = e_byte;
         h_kind_in  = e_kind;
      end else if (h_move) begin
         h_valid_in = 1'b0;
         h_res_in   = 1'b0;
         h_last_in  = 1'b0;
      end else if (fire && step_end && h_valid_ff && !h_res_ff) begin
         // burst ended without a token of its own: the held one is its last
         h_res_in  = 1'b1;
         h_last_in = 1'b1;
      end

      o_valid_in = o_valid_ff;
      o_last_in  = o_last_ff;
      o_byte_in  = o_byte_ff;
      o_kind_in  = o_kind_ff;
      if (h_move) begin
         o_valid_in = 1'b1;
         o_last_in  = h_last_ff;
         o_byte_in  = h_byte_ff;
         o_kind_in  = h_kind_ff;
      end else if (o_valid_ff && !rsp_stall) begin
         o_valid_in = 1'b0;
      end
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_out_byte   = o_byte_ff;
   assign rsp_token_kind = o_kind_ff;
   assign rsp_burst_last = o_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iml_ff     <= '0;
         rp_ff      <= '0;
         bi_ff      <= '0;
         quote_ff   <= 1'b0;
         fclosed_ff <= 1'b0;
         line_ff    <= 1'b0;
         fpend_ff   <= 1'b0;
         h_valid_ff <= 1'b0;
         h_res_ff   <= 1'b0;
         h_last_ff  <= 1'b0;
         o_valid_ff <= 1'b0;
         o_last_ff  <= 1'b0;
      end else begin
         if (fire) begin
            iml_ff     <= iml_in;
            rp_ff      <= rp_in;
            bi_ff      <= bi_in;
            quote_ff   <= quote_in;
            fclosed_ff <= fclosed_in;
            line_ff    <= line_in;
            fpend_ff   <= fpend_in;
         end
         h_valid_ff <= h_valid_in;
         h_res_ff   <= h_res_in;
         h_last_ff  <= h_last_in;
         o_valid_ff <= o_valid_in;
         o_last_ff  <= o_last_in;
      end
   end

   always_ff @(posedge clock) begin
      h_byte_ff <= h_byte_in;
      h_kind_ff <= h_kind_in;
      o_byte_ff <= o_byte_in;
      o_kind_ff <= o_kind_in;
      if (fire && hold_we) begin
         item_hold_ff[iml_ff[HW-1:0]] <= cur_byte;
      end
   end

endmodule

// ===== hw/rtl/delimited_row_tokenizer.sv =====
// ----------------------------------------------------------------------------
// delimited_row_tokenizer
// Splits a byte stream into rows and fields with multi-byte delimiters.
// ----------------------------------------------------------------------------
// Takes one stream byte per transfer and returns content bytes, field ends
// and row ends, with burst_last on the final token of each input byte.
// The back-end sequencer handles one line byte per step, or one token per
// step where a line byte yields several, so plain text runs at one byte per
// clock while neither the queue nor the result side stalls. A byte that breaks
// a partial item delimiter match first releases each held byte as content.
// A byte that breaks a partial row delimiter match also replays the held row
// bytes as line bytes. A row end releases each held item byte, then gives the
// field end if a field is open, and the row end. A four-entry queue between
// the row matcher and the sequencer absorbs these bursts. The first token of
// a transfer passes through the queue, the staging register and the output
// register. The user must write registers through the csr port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module delimited_row_tokenizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_text_byte,
   input  logic                               req_stream_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_out_byte,
   output logic [1:0]                         rsp_token_kind,
   output logic                               rsp_burst_last,
   input  logic                               csr_write,
   input  logic [drt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                        csr_wdata
);

   drt_pkg::cfg_type    cfg_ff, cfg_in;
   drt_pkg::entry_type  push_entry, head;
   logic                push, pop, head_valid, fifo_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            drt_pkg::CSR_ROW_BYTES:  cfg_in.row_bytes  = csr_wdata;
            drt_pkg::CSR_ROW_COUNT:  cfg_in.row_count  = csr_wdata[2:0];
            drt_pkg::CSR_ITEM_BYTES: cfg_in.item_bytes = csr_wdata;
            drt_pkg::CSR_ITEM_COUNT: cfg_in.item_count = csr_wdata[2:0];
            drt_pkg::CSR_QUOTES_EN:  cfg_in.quotes_en  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_bytes  <= 32'd10;
         cfg_ff.row_count  <= 3'd1;
         cfg_ff.item_bytes <= 32'd44;
         cfg_ff.item_count <= 3'd1;
         cfg_ff.quotes_en  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   drt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_stream_end (req_stream_end),
      .fifo_full      (fifo_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   drt_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (head_valid),
      .full       (fifo_full)
   );

   drt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .head           (head),
      .head_valid     (head_valid),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_token_kind (rsp_token_kind),
      .rsp_burst_last (rsp_burst_last)
   );

endmodule

// ===== test/delimited_row_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_row_tokenizer_tb
// Self-checking bench for the row/field tokenizer with multi-byte delimiters.
// ----------------------------------------------------------------------------
// A behavioral tokenizer inside the bench predicts the token burst of every
// byte as it is offered. A monitor compares each result transfer with the
// oldest predicted token. Directed streams cover the default format,
// multi-byte delimiters and quoting. Randomized phases then run several
// register settings with mostly well-formed rows and some noise. One phase
// holds the result side off for a long stretch, and the last phase runs
// with no idling on either side.
// ----------------------------------------------------------------------------
module delimited_row_tokenizer_tb;

   localparam int DLIM = drt_pkg::DELIM_LIM;
   localparam logic [7:0] CR = 8'h0D;
   localparam logic [7:0] LF = 8'h0A;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      logic       last;
   } token_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [7:0]                    req_text_byte;
   logic                          req_stream_end;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [7:0]                    rsp_out_byte;
   logic [1:0]                    rsp_token_kind;
   logic                          rsp_burst_last;
   logic                          csr_write;
   logic [drt_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                   csr_wdata;

   delimited_row_tokenizer dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_stream_end (req_stream_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_token_kind (rsp_token_kind),
      .rsp_burst_last (rsp_burst_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tokenizer settings and state as the bench sees them
   logic [31:0] cfg_row_bytes  = 32'd10;
   logic [2:0]  cfg_row_count  = 3'd1;
   logic [31:0] cfg_item_bytes = 32'd44;
   logic [2:0]  cfg_item_count = 3'd1;
   logic        cfg_quotes     = 1'b0;

   logic [7:0] row_held [DLIM];
   logic [7:0] item_held [DLIM];
   int         row_held_n   = 0;
   int         item_held_n  = 0;
   bit         in_quote     = 0;
   bit         quote_closed = 0;
   bit         line_seen    = 0;
   bit         field_open   = 0;

   token_type burst[$];
   token_type tokens_due[$];

   int items_sent    = 0;
   int tokens_seen   = 0;
   int mismatches    = 0;
   int settings_used = 1;
   int hold_cycles   = 0;
   bit gaps_on       = 1;
   bit stalls_on     = 1;

   function automatic int span(input logic [2:0] count);
      if (count == 3'd0) return 1;
      if (int'(count) > DLIM) return DLIM;
      return int'(count);
   endfunction

   function automatic logic [7:0] nth_byte(input logic [31:0] pbytes, input int k);
      return pbytes[8*(k%4) +: 8];
   endfunction

   function automatic void push_token(input logic [7:0] data, input logic [1:0] kind);
      token_type t;
      t.data = data;
      t.kind = kind;
      t.last = 1'b0;
      burst.insert(burst.size(), t);
   endfunction

   function automatic void put_content(input logic [7:0] c);
      if (!quote_closed) push_token(c, drt_pkg::TOK_CONTENT);
   endfunction

   function automatic void flush_item_held();
      for (int k = 0; k < item_held_n; k++) put_content(item_held[k]);
      item_held_n = 0;
   endfunction

   function automatic void feed_line_byte(input logic [7:0] c);
      int il;
      il = span(cfg_item_count);
      line_seen = 1;
      if (cfg_quotes && c == drt_pkg::QUOTE_CHAR) begin
         in_quote = !in_quote;
         if (in_quote) begin
            flush_item_held();
            field_open = 1;
            return;
         end
         // closing quote still goes through the delimiter matcher
         quote_closed = 1;
      end else if (in_quote) begin
         put_content(c);
         field_open = 1;
         return;
      end
      if (item_held_n < il && c == nth_byte(cfg_item_bytes, item_held_n)) begin
         item_held[item_held_n] = c;
         item_held_n++;
         if (item_held_n >= il) begin
            push_token(8'h00, drt_pkg::TOK_FIELD_END);
            item_held_n  = 0;
            quote_closed = 0;
            field_open   = 0;
         end else begin
            field_open = 1;
         end
      end else begin
         flush_item_held();
         put_content(c);
         field_open = 1;
      end
   endfunction

   function automatic void close_line();
      if (line_seen) begin
         flush_item_held();
         if (field_open) push_token(8'h00, drt_pkg::TOK_FIELD_END);
      end
      push_token(8'h00, drt_pkg::TOK_ROW_END);
      item_held_n  = 0;
      in_quote     = 0;
      quote_closed = 0;
      line_seen    = 0;
      field_open   = 0;
   endfunction

   function automatic void predict_tokens(input logic [7:0] b, input logic eos);
      int rl;
      rl = span(cfg_row_count);
      burst.delete();
      if (eos) begin
         row_held_n = 0;
         if (line_seen) begin
            close_line();
         end else begin
            item_held_n  = 0;
            in_quote     = 0;
            quote_closed = 0;
            field_open   = 0;
         end
      end else if (row_held_n < rl && b == nth_byte(cfg_row_bytes, row_held_n)) begin
         row_held[row_held_n] = b;
         row_held_n++;
         if (row_held_n >= rl) begin
            row_held_n = 0;
            close_line();
         end
      end else begin
         // broken row match: held bytes become line bytes, no retry
         for (int k = 0; k < row_held_n; k++) feed_line_byte(row_held[k]);
         row_held_n = 0;
         feed_line_byte(b);
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) tokens_due.insert(tokens_due.size(), burst[i]);
   endfunction

   // stream side -------------------------------------------------------------

   task automatic send_item(input logic [7:0] b, input logic eos);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      predict_tokens(b, eos);
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_stream_end <= eos;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   task automatic send_eos();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_delim(input logic [31:0] pbytes, input int n);
      for (int k = 0; k < n; k++) send_item(nth_byte(pbytes, k), 1'b0);
   endtask

   // biased toward delimiter bytes and quotes so partial matches happen often
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return nth_byte(cfg_row_bytes, $urandom_range(0, span(cfg_row_count) - 1));
         1, 2:    return nth_byte(cfg_item_bytes, $urandom_range(0, span(cfg_item_count) - 1));
         3:       return drt_pkg::QUOTE_CHAR;
         4:       return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h61, 8'h7a));
      endcase
   endfunction

   task automatic send_field();
      bit quoted;
      quoted = cfg_quotes && ($urandom_range(0, 2) == 0);
      if (quoted) send_item(drt_pkg::QUOTE_CHAR, 1'b0);
      repeat ($urandom_range(0, 5)) send_item(pick_byte(), 1'b0);
      if (quoted) begin
         send_item(drt_pkg::QUOTE_CHAR, 1'b0);
         if ($urandom_range(0, 3) == 0) send_item(pick_byte(), 1'b0);
      end
   endtask

   // one row, a burst of noise, or an end of stream
   task automatic send_chunk();
      int shape;
      int nf;
      int rl;
      int il;
      shape = $urandom_range(0, 9);
      rl = span(cfg_row_count);
      il = span(cfg_item_count);
      if (shape == 0) begin
         repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (shape == 1) begin
         send_eos();
      end else begin
         nf = $urandom_range(1, 4);
         for (int f = 0; f < nf; f++) begin
            if (f > 0) begin
               if (shape == 3) send_delim(cfg_item_bytes, $urandom_range(0, il - 1));
               else send_delim(cfg_item_bytes, il);
            end
            send_field();
         end
         if (shape == 2) send_delim(cfg_row_bytes, $urandom_range(0, rl - 1));
         else send_delim(cfg_row_bytes, rl);
      end
   endtask

   // wait out every predicted token, then the pipeline tail
   task automatic settle();
      req_valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] rb, input logic [2:0] rc,
                             input logic [31:0] ib, input logic [2:0] ic,
                             input logic q);
      csr_write <= 1'b1;
      csr_index <= drt_pkg::CSR_ROW_BYTES;
      csr_wdata <= rb;
      @(posedge clock);
      csr_index <= drt_pkg::CSR_ROW_COUNT;
      csr_wdata <= {29'd0, rc};
      @(posedge clock);
      csr_index <= drt_pkg::CSR_ITEM_BYTES;
      csr_wdata <= ib;
      @(posedge clock);
      csr_index <= drt_pkg::CSR_ITEM_COUNT;
      csr_wdata <= {29'd0, ic};
      @(posedge clock);
      csr_index <= drt_pkg::CSR_QUOTES_EN;
      csr_wdata <= {31'd0, q};
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_row_bytes  = rb;
      cfg_row_count  = rc;
      cfg_item_bytes = ib;
      cfg_item_count = ic;
      cfg_quotes     = q;
      settings_used++;
   endtask

   // tests -------------------------------------------------------------------

   // reset format: LF rows, comma items, quotes are plain bytes
   task automatic test_default_format();
      send_item(8'h00, 1'b0);
      send_text(",");
      send_item(8'hFF, 1'b0);
      send_text("\",");
      send_item(LF, 1'b0);
      send_item(LF, 1'b0);   // empty line
      send_eos();            // nothing pending
      settle();
   endtask

   // CR LF rows, three-byte items, quoting on
   task automatic test_multibyte_quoted();
      set_config(32'h0000_0A0D, 3'd2, 32'h003E_7C3C, 3'd3, 1'b1);
      // quote opens inside a partial match, delimiter inside quotes, delimiter right after close
      send_text("<\"x<|>\"<|>");
      // broken partial match, then a partial match left at line end
      send_text("<|y<|");
      send_item(CR, 1'b0);
      send_item(LF, 1'b0);
      // broken row match, then a trailing partial row dropped at end of stream
      send_item(CR, 1'b0);
      send_text("b");
      send_item(CR, 1'b0);
      send_eos();
      settle();
   endtask

   task automatic run_phase(input logic [31:0] rb, input logic [2:0] rc,
                            input logic [31:0] ib, input logic [2:0] ic,
                            input logic q, input int budget);
      int first;
      set_config(rb, rc, ib, ic, q);
      first = items_sent;
      while (items_sent - first < budget) send_chunk();
      send_eos();
      settle();
   endtask

   task automatic test_random_settings();
      // count 0 taken as 1, count 7 clipped
      run_phase($urandom, 3'd0, $urandom, 3'd7, 1'b1, 40);
      // item delimiter starts with a quote, so closing quotes can match
      run_phase($urandom, 3'd4, ($urandom & 32'hFFFF_FF00) | 32'(drt_pkg::QUOTE_CHAR),
                3'($urandom_range(1, 2)), 1'b1, 40);
      run_phase($urandom, 3'd2, $urandom, 3'd3, 1'b0, 40);
      run_phase($urandom, 3'd3, $urandom, 3'd4, 1'b1, 40);
   endtask

   // result side held off long enough to back the block up into its input
   task automatic test_backpressure();
      int first;
      gaps_on = 0;
      hold_cycles = 300;
      first = items_sent;
      while (items_sent - first < 35) send_chunk();
      send_eos();
      settle();
      gaps_on = 1;
   endtask

   task automatic test_unthrottled_tail();
      gaps_on = 0;
      stalls_on = 0;
      run_phase(32'hFFFF_FFFF, 3'd1, 32'h0000_0000, 3'd1, 1'b0, 35);
   endtask

   // result side -------------------------------------------------------------

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      token_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_seen++;
         if (tokens_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token %0d: byte %02h kind %0d last %0b",
                        tokens_seen, rsp_out_byte, rsp_token_kind, rsp_burst_last);
         end else begin
            want = tokens_due.pop_front();
            if (rsp_out_byte !== want.data || rsp_token_kind !== want.kind ||
                rsp_burst_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"token %0d mismatch: expected byte %02h kind %0d last %0b,",
                            " got byte %02h kind %0d last %0b"},
                           tokens_seen, want.data, want.kind, want.last,
                           rsp_out_byte, rsp_token_kind, rsp_burst_last);
            end
         end
      end
   end

   // main sequence -----------------------------------------------------------

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_text_byte  = 8'h00;
      req_stream_end = 1'b0;
      csr_write      = 1'b0;
      csr_index      = drt_pkg::CSR_ROW_BYTES;
      csr_wdata      = 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_format();
      test_multibyte_quoted();
      test_random_settings();
      test_backpressure();
      test_unthrottled_tail();

      req_valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("covered %0d input transfers and %0d result transfers",
               items_sent, tokens_seen);
      $display("over %0d register settings, with quoting, multi-byte delimiters, %s",
               settings_used, "stream ends and a long output hold-off");
      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d tokens still expected", mismatches, tokens_due.size());
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d tokens still expected", tokens_due.size());
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/drt_pkg.sv
hw/rtl/drt_front.sv
hw/rtl/drt_fifo.sv
hw/rtl/drt_back.sv
hw/rtl/delimited_row_tokenizer.sv
test/delimited_row_tokenizer_tb.sv
